### design/amb_pkg.sv
package amb_pkg;

    // Blend modes held in register 0
    typedef enum logic [1:0] {
        MODE_TRANSPARENT = 2'd0,
        MODE_OPAQUE      = 2'd1,
        MODE_REVERSED    = 2'd2
    } t_blend_mode;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_BLEND_MODE = 3'd0,
        REG_FG_WORD    = 3'd1,
        REG_BG_WORD    = 3'd2,
        REG_FG_RGB     = 3'd3,
        REG_BG_RGB     = 3'd4
    } t_cfg_reg;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 32;

    localparam logic [7:0] COV_NONE = 8'h00;
    localparam logic [7:0] COV_FULL = 8'hFF;

    // Input item
    typedef struct packed {
        logic [7:0]  coverage;
        logic [31:0] dest_pixel;
    } t_pix_in;

    // Result item
    typedef struct packed {
        logic [31:0] new_pixel;
        logic        write_enable;
    } t_pix_out;

    // One channel: (d*(255-a) + s*a) rounded, divided by 255 without a divider.
    // Rewritten as d*255 + (s-d)*a so only one 9x9 signed multiply is needed.
    function automatic logic [7:0] chan_mix(input logic [7:0] a,
                                            input logic [7:0] s,
                                            input logic [7:0] d);
        logic signed [8:0]  diff;
        logic signed [8:0]  a_s;
        logic signed [17:0] prod;
        logic [16:0]        base;
        logic signed [17:0] x_s;
        logic [16:0]        x;
        logic [16:0]        y;
        diff = $signed({1'b0, s}) - $signed({1'b0, d});
        a_s  = $signed({1'b0, a});
        prod = diff * a_s;
        base = {1'b0, d, 8'h00} - {9'h000, d};
        x_s  = $signed({1'b0, base}) + prod;
        x    = x_s[16:0];
        y    = x + 17'd128 + {8'h00, x[16:8]};
        return y[15:8];
    endfunction

    // Per-channel blend of 0xRRGGBB source over 0xRRGGBB destination
    function automatic logic [23:0] mix_rgb(input logic [7:0]  a,
                                            input logic [23:0] src,
                                            input logic [23:0] dst);
        return {chan_mix(a, src[23:16], dst[23:16]),
                chan_mix(a, src[15:8],  dst[15:8]),
                chan_mix(a, src[7:0],   dst[7:0])};
    endfunction

endpackage

### design/alpha_mask_pixel_blend_top.sv
// Channel   Direction  Handshake                 Payload
// pixel in  input      i_valid / o_stall         i_pix  (amb_pkg::t_pix_in)
// result    output     o_valid / i_stall         o_pix  (amb_pkg::t_pix_out)
// config    input      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One item per cycle sustained while i_stall is low; input register, then
// result register, with the per-channel multiply-and-round between them.
// Reset (synchronous, active low) empties both stages and clears the registers.
// The input register refills whenever the result register is free or taken
// in the same cycle, so o_stall rises only when both stages hold an item and
// the result is stalled. Config writes are always taken (o_cfg_ready high).
module alpha_mask_pixel_blend_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  amb_pkg::t_pix_in                   i_pix,
    output logic                               o_valid,
    input  logic                               i_stall,
    output amb_pkg::t_pix_out                  o_pix,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [amb_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [amb_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    amb_pkg::t_blend_mode r_mode;
    logic [31:0]          r_fg_word;
    logic [31:0]          r_bg_word;
    logic [23:0]          r_fg_rgb;
    logic [23:0]          r_bg_rgb;

    logic                 r_s1_valid;
    amb_pkg::t_pix_in     r_s1;
    logic                 r_out_valid;
    amb_pkg::t_pix_out    r_out;
    amb_pkg::t_pix_out    n_out;

    logic                 w_advance;
    logic                 w_in_accept;
    logic [7:0]           w_inv;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= amb_pkg::MODE_TRANSPARENT;
            r_fg_word <= '0;
            r_bg_word <= '0;
            r_fg_rgb  <= '0;
            r_bg_rgb  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (amb_pkg::t_cfg_reg'(i_cfg_index))
                amb_pkg::REG_BLEND_MODE: r_mode    <= amb_pkg::t_blend_mode'(i_cfg_data[1:0]);
                amb_pkg::REG_FG_WORD:    r_fg_word <= i_cfg_data;
                amb_pkg::REG_BG_WORD:    r_bg_word <= i_cfg_data;
                amb_pkg::REG_FG_RGB:     r_fg_rgb  <= i_cfg_data[23:0];
                amb_pkg::REG_BG_RGB:     r_bg_rgb  <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    // Flow control: stage 1 moves on when the result register is free or taken
    assign w_advance   = !r_out_valid || !i_stall;
    assign o_stall     = r_s1_valid && !w_advance;
    assign w_in_accept = i_valid && !o_stall;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_s1 <= i_pix;
        end
    end

    // Blend selection
    assign w_inv = ~r_s1.coverage;

    always_comb begin
        n_out.new_pixel    = r_s1.dest_pixel;
        n_out.write_enable = 1'b0;
        case (r_mode)
            amb_pkg::MODE_TRANSPARENT: begin
                if (r_s1.coverage == amb_pkg::COV_FULL) begin
                    n_out.new_pixel    = r_fg_word;
                    n_out.write_enable = 1'b1;
                end else if (r_s1.coverage != amb_pkg::COV_NONE) begin
                    n_out.new_pixel    = {8'h00, amb_pkg::mix_rgb(r_s1.coverage, r_fg_rgb,
                                                                  r_s1.dest_pixel[23:0])};
                    n_out.write_enable = 1'b1;
                end
            end
            amb_pkg::MODE_OPAQUE: begin
                n_out.write_enable = 1'b1;
                if (r_s1.coverage == amb_pkg::COV_NONE) begin
                    n_out.new_pixel = r_bg_word;
                end else if (r_s1.coverage == amb_pkg::COV_FULL) begin
                    n_out.new_pixel = r_fg_word;
                end else begin
                    n_out.new_pixel = {8'h00, amb_pkg::mix_rgb(r_s1.coverage, r_fg_rgb,
                                                               r_bg_rgb)};
                end
            end
            amb_pkg::MODE_REVERSED: begin
                if (w_inv == amb_pkg::COV_FULL) begin
                    n_out.new_pixel    = r_bg_word;
                    n_out.write_enable = 1'b1;
                end else if (w_inv != amb_pkg::COV_NONE) begin
                    n_out.new_pixel    = {8'h00, amb_pkg::mix_rgb(w_inv, r_bg_rgb,
                                                                  r_s1.dest_pixel[23:0])};
                    n_out.write_enable = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && r_s1_valid) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_pix   = r_out;

    // Checks
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_s1_valid && r_out_valid && i_stall))
        else $error("input stalled while a stage is free");

    a_stage_moves_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && w_advance) |=> r_out_valid)
        else $error("item lost between stages");

    a_full_cov_native: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && w_advance && r_mode == amb_pkg::MODE_TRANSPARENT
         && r_s1.coverage == amb_pkg::COV_FULL)
        |=> (r_out.write_enable && r_out.new_pixel == $past(r_fg_word)))
        else $error("full coverage did not write the native foreground word");

endmodule
